// File: src/svn2d_pkg.sv
package svn2d_pkg;

  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned LatW = 32;
  localparam int unsigned SmW = 38;   // Q4.34 smoothed value, signed
  localparam int unsigned WBits = 24;
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] HashRowMul = 32'd57;
  localparam int unsigned HashShift = 13;
  localparam logic [31:0] HashPa = 32'd995615039;
  localparam logic [31:0] HashPb = 32'd600173719;
  localparam logic [31:0] HashPc = 32'd701464987;

  typedef struct packed {
    logic [LatW-1:0]  ix;
    logic [LatW-1:0]  iy;
    logic [WBits:0]   wx;
    logic [WBits:0]   wy;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkHash,
    BkBlend
  } bk_state_e;

endpackage

// File: src/svn2d_fade.sv
// Quintic fade, 4 register stages.
module svn2d_fade (
  input  logic clk_i,
  input  logic en_i,
  input  logic [svn2d_pkg::FracW-1:0] u_i,
  output logic [svn2d_pkg::WBits:0] w_o
);
  import svn2d_pkg::*;

  logic [FracW-1:0] u1_q;
  logic signed [21:0] p1_q;
  logic [31:0] uu_q;
  logic [35:0] q_q;
  logic [47:0] c_q;
  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q   <= u_i;
      p1_q   <= $signed({6'd0, u_i}) * 22'sd6 - 22'sd983040;
      uu_q   <= 32'(u_i) * 32'(u_i);
      q_q    <= 36'($signed({1'b0, u1_q}) * p1_q + 37'sd42949672960);
      c_q    <= 48'(uu_q) * 48'(u1_q);
      prod_q <= 64'(c_q[47:16]) * 64'(q_q[35:16]);
      w_o    <= prod_q[28 +: WBits+1];
    end
  end
endmodule

// File: src/svn2d_hash.sv
// Lattice hash, registered between multiplies.
module svn2d_hash (
  input  logic clk_i,
  input  logic [31:0] lx_i,
  input  logic [31:0] ly_i,
  output logic signed [31:0] val_o
);
  import svn2d_pkg::*;

  logic [31:0] n0, n_q, nn_q, n2_q, n3_q, m_q, t;

  always_comb begin
    n0 = lx_i + ly_i * HashRowMul;
    n0 = (n0 << HashShift) ^ n0;
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n0;
    nn_q <= n_q * n_q;
    n2_q <= n_q;
    m_q  <= nn_q * HashPa + HashPb;
    n3_q <= n2_q;
  end

  always_comb t = (n3_q * m_q + HashPc) & 32'h7fffffff;

  assign val_o = $signed(32'h40000000 - t);
endmodule

// File: src/svn2d_front.sv
// Splits coordinates, runs the fade, fills the job queue.
module svn2d_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic signed [svn2d_pkg::CoordW-1:0] x_coord_i,
  input  logic signed [svn2d_pkg::CoordW-1:0] y_coord_i,
  input  logic valid_i,
  output logic stall_o,
  output svn2d_pkg::job_t job_o,
  output logic job_valid_o,
  input  logic job_pop_i
);
  import svn2d_pkg::*;

  localparam int unsigned Lat = 4;
  localparam int unsigned Slots = QueueDepth + Lat + 1;
  localparam int unsigned CntW = $clog2(Slots + 1);

  logic [FracW-1:0] ux, uy;
  logic [WBits:0] wx, wy;
  logic [Lat-1:0] v_q;
  logic [LatW-1:0] ix_q [Lat];
  logic [LatW-1:0] iy_q [Lat];
  job_t fifo_q [QueueDepth+Lat+1];
  logic [CntW-1:0] cnt_q, pend_q;
  logic [$clog2(Slots)-1:0] wp_q, rp_q;
  logic acc, adv;

  always_comb begin
    if (CoordFracBits >= FracW) begin
      ux = x_coord_i[CoordFracBits-1 -: FracW];
      uy = y_coord_i[CoordFracBits-1 -: FracW];
    end else begin
      ux = FracW'({x_coord_i[CoordFracBits-1:0]} << (FracW - CoordFracBits));
      uy = FracW'({y_coord_i[CoordFracBits-1:0]} << (FracW - CoordFracBits));
    end
  end

  // credit: items in flight plus queued never exceed the queue
  assign stall_o = (32'(cnt_q) + 32'(pend_q)) >= Slots;
  assign acc = valid_i && !stall_o;
  assign adv = 1'b1;

  svn2d_fade u_fx (.clk_i, .en_i(adv), .u_i(ux), .w_o(wx));
  svn2d_fade u_fy (.clk_i, .en_i(adv), .u_i(uy), .w_o(wy));

  always_ff @(posedge clk_i) begin
    ix_q[0] <= LatW'(x_coord_i >>> CoordFracBits);
    iy_q[0] <= LatW'(y_coord_i >>> CoordFracBits);
    for (int i = 1; i < Lat; i++) begin
      ix_q[i] <= ix_q[i-1];
      iy_q[i] <= iy_q[i-1];
    end
    if (v_q[Lat-1]) fifo_q[wp_q] <= '{ix: ix_q[Lat-1], iy: iy_q[Lat-1], wx: wx, wy: wy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0; cnt_q <= '0; pend_q <= '0; wp_q <= '0; rp_q <= '0;
    end else begin
      v_q <= {v_q[Lat-2:0], acc};
      pend_q <= pend_q + CntW'(acc) - CntW'(v_q[Lat-1]);
      cnt_q <= cnt_q + CntW'(v_q[Lat-1]) - CntW'(job_pop_i);
      if (v_q[Lat-1]) wp_q <= (32'(wp_q) == Slots-1) ? '0 : wp_q + 1'b1;
      if (job_pop_i) rp_q <= (32'(rp_q) == Slots-1) ? '0 : rp_q + 1'b1;
    end
  end

  assign job_o = fifo_q[rp_q];
  assign job_valid_o = cnt_q != '0;
endmodule

// File: src/svn2d_back.sv
// Four hash units, one row at a time, build the 16 lattice values, then smooth and blend.
module svn2d_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  svn2d_pkg::job_t job_i,
  input  logic job_valid_i,
  output logic job_pop_o,
  output logic signed [31:0] noise_value_o,
  output logic valid_o,
  input  logic stall_i
);
  import svn2d_pkg::*;

  localparam int unsigned HLat = 3;
  localparam int unsigned BLat = 5;

  job_t job_q;
  logic [1:0] row_q;
  logic busy_q;
  logic [HLat-1:0] hv_q;
  logic [1:0] hrow_q [HLat];
  logic [31:0] lx [4];
  logic [31:0] ly;
  logic signed [31:0] hval [4];
  logic signed [31:0] lat_q [4][4];
  logic signed [WBits:0] wx_h [HLat+1], wy_h [HLat+1];
  logic go_q;
  logic [BLat-1:0] bv_q;
  logic signed [SmW-1:0] s_q [4];
  logic signed [WBits:0] wx1_q, wy1_q, wy2_q, wy3_q;
  logic signed [SmW+WBits+1:0] m1_q, m2_q, m3_q;
  logic signed [SmW-1:0] a1_q, a2_q, i1_q, i2_q, ia_q, r_q;
  logic signed [31:0] oq_q [4];
  logic [1:0] owp_q, orp_q;
  logic [2:0] oc_q;
  logic [2:0] infl_q;
  logic start, done_b, outfire;

  assign outfire = valid_o && !stall_i;
  // result credit: pipeline plus output buffer
  assign start = job_valid_i && (!busy_q || row_q == 2'd3) && (infl_q < 3'd4);
  assign job_pop_o = start;

  for (genvar k = 0; k < 4; k++) begin : g_h
    assign lx[k] = job_q.ix + 32'(k) - 32'd1;
    svn2d_hash u_h (.clk_i, .lx_i(lx[k]), .ly_i(ly), .val_o(hval[k]));
  end
  assign ly = job_q.iy + 32'(row_q) - 32'd1;

  always_ff @(posedge clk_i) begin
    if (start) job_q <= job_i;
    hrow_q[0] <= row_q;
    wx_h[0] <= job_q.wx; wy_h[0] <= job_q.wy;
    for (int i = 1; i < HLat; i++) hrow_q[i] <= hrow_q[i-1];
    for (int i = 1; i <= HLat; i++) begin wx_h[i] <= wx_h[i-1]; wy_h[i] <= wy_h[i-1]; end
    if (hv_q[HLat-1]) for (int k = 0; k < 4; k++) lat_q[hrow_q[HLat-1]][k] <= hval[k];
    if (go_q) begin
      for (int c = 0; c < 4; c++)
        s_q[c] <= SmW'(lat_q[c/2][c%2]) + SmW'(lat_q[c/2][c%2+2]) + SmW'(lat_q[c/2+2][c%2])
                + SmW'(lat_q[c/2+2][c%2+2])
                + 2 * (SmW'(lat_q[c/2][c%2+1]) + SmW'(lat_q[c/2+2][c%2+1])
                + SmW'(lat_q[c/2+1][c%2]) + SmW'(lat_q[c/2+1][c%2+2]))
                + 4 * SmW'(lat_q[c/2+1][c%2+1]);
      wx1_q <= wx_h[HLat]; wy1_q <= wy_h[HLat];
    end
    a1_q <= s_q[0]; a2_q <= s_q[2];
    m1_q <= (s_q[1] - s_q[0]) * wx1_q;
    m2_q <= (s_q[3] - s_q[2]) * wx1_q;
    wy2_q <= wy1_q;
    i1_q <= a1_q + SmW'(m1_q >>> WBits);
    i2_q <= a2_q + SmW'(m2_q >>> WBits);
    wy3_q <= wy2_q;
    ia_q <= i1_q;
    m3_q <= (i2_q - i1_q) * wy3_q;
    r_q <= ia_q + SmW'(m3_q >>> WBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; row_q <= '0; hv_q <= '0; go_q <= 1'b0; bv_q <= '0;
      infl_q <= '0;
    end else begin
      if (start) begin busy_q <= 1'b1; row_q <= '0; end
      else if (busy_q) begin
        row_q <= row_q + 1'b1;
        if (row_q == 2'd3) busy_q <= 1'b0;
      end
      hv_q <= {hv_q[HLat-2:0], busy_q};
      go_q <= hv_q[HLat-1] && hrow_q[HLat-1] == 2'd3;
      bv_q <= {bv_q[BLat-2:0], go_q};
      infl_q <= infl_q + 3'(start) - 3'(outfire);
    end
  end

  assign done_b = bv_q[BLat-1];

  // output buffer, four words; credit keeps it from overflowing
  always_ff @(posedge clk_i) begin
    if (done_b) oq_q[owp_q] <= 32'((r_q < 0) ? -((-r_q) >>> 4) : (r_q >>> 4));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q <= '0; orp_q <= '0; oc_q <= '0;
    end else begin
      if (done_b) owp_q <= owp_q + 1'b1;
      if (outfire) orp_q <= orp_q + 1'b1;
      oc_q <= oc_q + 3'(done_b) - 3'(outfire);
    end
  end
  assign noise_value_o = oq_q[orp_q];
  assign valid_o = oc_q != '0;
endmodule

// File: src/smoothed_value_noise_2d_unit.sv
// 2D smoothed value noise. Takes a Q16.16 point and gives a Q2.30 value.
// The four shared lattice hash units cover one row of the 4x4 neighborhood per
// cycle, and new points enter while earlier ones are still in the pipeline. A
// queue of jobs sits between the coordinate front end and the hash/blend back
// end, and up to four results wait in the output buffer while the output is
// stalled.
module smoothed_value_noise_2d_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic valid_i,
  output logic stall_o,
  output logic signed [31:0] noise_value_o,
  output logic valid_o,
  input  logic stall_i
);
  import svn2d_pkg::*;

  job_t job;
  logic job_valid, job_pop;

  svn2d_front u_front (.clk_i, .rst_ni, .x_coord_i, .y_coord_i, .valid_i, .stall_o,
    .job_o(job), .job_valid_o(job_valid), .job_pop_i(job_pop));

  svn2d_back u_back (.clk_i, .rst_ni, .job_i(job), .job_valid_i(job_valid),
    .job_pop_o(job_pop), .noise_value_o, .valid_o, .stall_i);
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import svn2d_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic signed [31:0] x_coord_i;
  logic signed [31:0] y_coord_i;
  logic valid_i;
  logic stall_o;
  logic signed [31:0] noise_value_o;
  logic valid_o;
  logic stall_i;
  bit quiet;

  smoothed_value_noise_2d_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .x_coord_i(x_coord_i),
    .y_coord_i(y_coord_i),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .noise_value_o(noise_value_o),
    .valid_o(valid_o),
    .stall_i(stall_i)
  );

  class noise_scoreboard;
    logic signed [31:0] pending_noise[$];
    int errors;

    function longint lattice(bit [31:0] lx, bit [31:0] ly);
      bit [31:0] n;
      bit [31:0] t;
      n = lx + ly * HashRowMul;
      n = (n << HashShift) ^ n;
      t = (n * (n * n * HashPa + HashPb) + HashPc) & 32'h7fffffff;
      return (64'sd1 <<< 30) - longint'(t);
    endfunction

    function longint smooth_at(bit [31:0] cx, bit [31:0] cy);
      longint corners;
      longint sides;
      corners = lattice(cx - 1, cy - 1) + lattice(cx + 1, cy - 1)
              + lattice(cx - 1, cy + 1) + lattice(cx + 1, cy + 1);
      sides = lattice(cx - 1, cy) + lattice(cx + 1, cy)
            + lattice(cx, cy - 1) + lattice(cx, cy + 1);
      return corners + 2 * sides + 4 * lattice(cx, cy);
    endfunction

    function longint fade_weight(longint u);
      longint p;
      longint q;
      longint c;
      p = 6 * u - 15 * 65536;
      q = u * p + 10 * (64'sd1 <<< 32);
      c = u * u * u;
      return ((c >>> 16) * (q >>> 16)) >>> 28;
    endfunction

    function longint lerp(longint a, longint b, longint w);
      return a + (((b - a) * w) >>> WBits);
    endfunction

    function void split(logic signed [31:0] v, output bit [31:0] idx, output longint u);
      longint vl;
      longint ip;
      longint frac;
      vl = longint'(v);
      ip = vl >>> CoordFracBits;
      frac = vl - (ip <<< CoordFracBits);
      idx = ip[31:0];
      if (CoordFracBits >= 16) u = frac >>> (CoordFracBits - 16);
      else u = (frac <<< (16 - CoordFracBits)) & 64'hffff;
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y);
      bit [31:0] ix, iy;
      longint ux, uy, wx, wy, r1, r2, r, q;
      split(x, ix, ux);
      split(y, iy, uy);
      wx = fade_weight(ux);
      wy = fade_weight(uy);
      r1 = lerp(smooth_at(ix, iy), smooth_at(ix + 1, iy), wx);
      r2 = lerp(smooth_at(ix, iy + 1), smooth_at(ix + 1, iy + 1), wx);
      r = lerp(r1, r2, wy);
      q = r / 16;
      pending_noise.push_back(q[31:0]);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_noise(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending_noise.size() == 0) begin
        report($sformatf("unexpected word %0d", got));
      end else begin
        want = pending_noise.pop_front();
        if (got !== want) report($sformatf("noise_value got %0d want %0d", got, want));
      end
    endtask
  endclass

  noise_scoreboard sb = new();

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_point(logic signed [31:0] x, logic signed [31:0] y);
    int g;
    g = pick_gap();
    if (g > 0) begin
      valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    forever begin
      @(negedge clk_i);
      if (valid_i && !stall_o) begin
        sb.note_point(x, y);
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
  endtask

  initial begin
    int g;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        @(posedge clk_i);
        stall_i <= 1'b1;
        repeat (g - 1) @(posedge clk_i);
      end
      @(posedge clk_i);
      stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_noise(noise_value_o);
  end

  initial begin
    #5ms;
    $display("[smoothed_value_noise_2d_unit] ERROR");
    $finish;
  end

  initial begin
    logic signed [31:0] edge_vals[12];
    logic signed [31:0] x, y;
    int mode;
    edge_vals = '{32'sd0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd1, 32'sh00008000,
                  32'sh0000ffff, 32'sh00010000, -32'sh00010000, -32'sh00008000,
                  32'sh7fff0000, 32'sh8000ffff};
    rst_ni = 1'b0;
    valid_i = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    quiet = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 12; i++) send_point(edge_vals[i], edge_vals[(i * 5 + 3) % 12]);
    for (int i = 0; i < 12; i++) send_point(edge_vals[(i * 7) % 12], edge_vals[i]);
    for (int i = 0; i < 1600; i++) begin
      quiet = (i >= 600 && i < 800);
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        x = $urandom_range(0, 2047) - 1024;
        y = $urandom_range(0, 2047) - 1024;
      end else if (mode == 1) begin
        x = edge_vals[$urandom_range(0, 11)] + $urandom_range(0, 3) - 1;
        y = $urandom();
      end else begin
        x = $urandom();
        y = $urandom();
      end
      send_point(x, y);
    end
    quiet = 1'b0;
    valid_i <= 1'b0;
    while (sb.pending_noise.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_noise.size() == 0) begin
      $display("[smoothed_value_noise_2d_unit] OK");
    end else begin
      $display("[smoothed_value_noise_2d_unit] ERROR");
    end
    $finish;
  end

endmodule
